[hw/rtl/one_wire_bus_master_defines.svh]
// Assertion macros shared by the 1-Wire bus master RTL.
// No dependencies; included by the top level only.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OWM_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("owm assertion failed");

// Next-cycle implication, checked out of reset.
`define OWM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("owm assertion failed");

`endif

[hw/rtl/owm_pkg.sv]
// Types and constants of the 1-Wire bus master.
// No dependencies; used by owm_cfg_regs, owm_core and the top level.
package owm_pkg;

  localparam int unsigned TimeW = 10;
  localparam int unsigned IdxW  = 3;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // register indexes of the configuration port
  localparam logic [IdxW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [IdxW-1:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [IdxW-1:0] REG_SLOT_START    = 3'd2;
  localparam logic [IdxW-1:0] REG_WRITE_HOLD    = 3'd3;
  localparam logic [IdxW-1:0] REG_WRITE_RECOVER = 3'd4;
  localparam logic [IdxW-1:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [IdxW-1:0] REG_READ_RECOVER  = 3'd6;

  // power-on timing, in microsecond ticks
  localparam logic [TimeW-1:0] RST_RESET_LOW     = 10'd500;
  localparam logic [TimeW-1:0] RST_RESET_RELEASE = 10'd500;
  localparam logic [TimeW-1:0] RST_SLOT_START    = 10'd2;
  localparam logic [TimeW-1:0] RST_WRITE_HOLD    = 10'd60;
  localparam logic [TimeW-1:0] RST_WRITE_RECOVER = 10'd2;
  localparam logic [TimeW-1:0] RST_READ_SAMPLE   = 10'd8;
  localparam logic [TimeW-1:0] RST_READ_RECOVER  = 10'd120;

  typedef struct packed {
    logic [TimeW-1:0] reset_low;
    logic [TimeW-1:0] reset_release;
    logic [TimeW-1:0] slot_start;
    logic [TimeW-1:0] write_hold;
    logic [TimeW-1:0] write_recover;
    logic [TimeW-1:0] read_sample;
    logic [TimeW-1:0] read_recover;
  } cfg_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
  } res_t;

endpackage

[hw/rtl/owm_cfg_regs.sv]
// Timing register file of the 1-Wire bus master.
// Depends on owm_pkg.
module owm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owm_pkg::IdxW-1:0]        cfg_index,
  input  logic [owm_pkg::TimeW-1:0]       cfg_data,
  output owm_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low     <= owm_pkg::RST_RESET_LOW;
      cfg.reset_release <= owm_pkg::RST_RESET_RELEASE;
      cfg.slot_start    <= owm_pkg::RST_SLOT_START;
      cfg.write_hold    <= owm_pkg::RST_WRITE_HOLD;
      cfg.write_recover <= owm_pkg::RST_WRITE_RECOVER;
      cfg.read_sample   <= owm_pkg::RST_READ_SAMPLE;
      cfg.read_recover  <= owm_pkg::RST_READ_RECOVER;
    end else if (cfg_valid) begin
      case (cfg_index)
        owm_pkg::REG_RESET_LOW:     cfg.reset_low     <= cfg_data;
        owm_pkg::REG_RESET_RELEASE: cfg.reset_release <= cfg_data;
        owm_pkg::REG_SLOT_START:    cfg.slot_start    <= cfg_data;
        owm_pkg::REG_WRITE_HOLD:    cfg.write_hold    <= cfg_data;
        owm_pkg::REG_WRITE_RECOVER: cfg.write_recover <= cfg_data;
        owm_pkg::REG_READ_SAMPLE:   cfg.read_sample   <= cfg_data;
        owm_pkg::REG_READ_RECOVER:  cfg.read_recover  <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

[hw/rtl/owm_core.sv]
// Command sequencer and result register of the 1-Wire bus master.
// Depends on owm_pkg.
module owm_core #(
  parameter int unsigned BITS_PER_BYTE = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  owm_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [7:0]                data_byte,
  input  logic                      line_level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output owm_pkg::res_t             res
);

  localparam logic [2:0] LastBit = 3'(BITS_PER_BYTE - 1);

  owm_pkg::op_t                 operation, operation_next;
  logic [1:0]                   phase, phase_next;
  logic [owm_pkg::TimeW-1:0]    tick_count, tick_count_next;
  logic [2:0]                   bit_index, bit_index_next;
  logic [7:0]                   send_shift, send_shift_next;
  logic [7:0]                   receive_shift, receive_shift_next;
  logic [7:0]                   last_read, last_read_next;
  logic                         done_next;
  logic [owm_pkg::TimeW-1:0]    phase_len_raw, phase_len, tick_inc;
  logic                         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // length of the current phase; a zero setting acts as one tick
  always_comb begin
    case (operation)
      owm_pkg::OP_RESET:
        phase_len_raw = (phase == 2'd0) ? cfg.reset_low : cfg.reset_release;
      owm_pkg::OP_WRITE:
        phase_len_raw = (phase == 2'd0) ? cfg.slot_start :
                        (phase == 2'd1) ? cfg.write_hold : cfg.write_recover;
      owm_pkg::OP_READ:
        phase_len_raw = (phase == 2'd0) ? cfg.slot_start :
                        (phase == 2'd1) ? cfg.read_sample : cfg.read_recover;
      default:
        phase_len_raw = owm_pkg::TimeW'(1);
    endcase
    phase_len = (phase_len_raw == '0) ? owm_pkg::TimeW'(1) : phase_len_raw;
  end

  assign tick_inc = tick_count + owm_pkg::TimeW'(1);

  always_comb begin
    logic finished;
    finished           = 1'b0;
    operation_next     = operation;
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    send_shift_next    = send_shift;
    receive_shift_next = receive_shift;
    last_read_next     = last_read;
    done_next          = 1'b0;

    if (mode != 2'd0) begin
      if (operation == owm_pkg::OP_IDLE) begin
        operation_next  = owm_pkg::op_t'(mode);
        phase_next      = 2'd0;
        tick_count_next = '0;
        bit_index_next  = 3'd0;
        if (owm_pkg::op_t'(mode) == owm_pkg::OP_WRITE) send_shift_next = data_byte;
        if (owm_pkg::op_t'(mode) == owm_pkg::OP_READ) receive_shift_next = 8'd0;
      end
    end else if (operation != owm_pkg::OP_IDLE) begin
      tick_count_next = tick_inc;
      if (tick_inc >= phase_len) begin
        tick_count_next = '0;
        if (operation == owm_pkg::OP_RESET) begin
          if (phase == 2'd0) phase_next = 2'd1;
          else finished = 1'b1;
        end else begin
          if (operation == owm_pkg::OP_READ && phase == 2'd1)
            receive_shift_next[bit_index] = receive_shift[bit_index] | line_level;
          if (phase < 2'd2) begin
            phase_next = phase + 2'd1;
          end else if (bit_index == LastBit) begin
            finished = 1'b1;
          end else begin
            bit_index_next  = bit_index + 3'd1;
            send_shift_next = {1'b0, send_shift[7:1]};
            phase_next      = 2'd0;
          end
        end
        if (finished) begin
          if (operation == owm_pkg::OP_READ) last_read_next = receive_shift_next;
          operation_next = owm_pkg::OP_IDLE;
          phase_next     = 2'd0;
          bit_index_next = 3'd0;
          done_next      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation     <= owm_pkg::OP_IDLE;
      phase         <= 2'd0;
      tick_count    <= '0;
      bit_index     <= 3'd0;
      send_shift    <= 8'd0;
      receive_shift <= 8'd0;
      last_read     <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        operation     <= operation_next;
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        send_shift    <= send_shift_next;
        receive_shift <= receive_shift_next;
        last_read     <= last_read_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // result register: drive level after the step, status and last read byte
  always_ff @(posedge clk) begin
    if (accept) begin
      res.pull_low  <= (operation_next != owm_pkg::OP_IDLE) &&
                       ((phase_next == 2'd0) ||
                        (operation_next == owm_pkg::OP_WRITE && phase_next == 2'd1 &&
                         !send_shift_next[0]));
      res.busy      <= (operation_next != owm_pkg::OP_IDLE);
      res.done      <= done_next;
      res.read_byte <= last_read_next;
    end
  end

endmodule

[hw/rtl/one_wire_bus_master.sv]
// 1-Wire bus master in microsecond ticks: one result beat per input beat.
// Latency: the result of an accepted beat shows on the next cycle.
// Throughput: one beat per cycle; the sequencer's one-step update and the
// result register set it, with out_ready back-pressure stalling input.
// Reset (rst, synchronous): idle sequencer, stored read byte zero, timing defaults; result register not reset.
`include "one_wire_bus_master_defines.svh"
module one_wire_bus_master #(
  parameter int unsigned BITS_PER_BYTE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // timing register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [owm_pkg::IdxW-1:0]    cfg_index,
  input  logic [owm_pkg::TimeW-1:0]   cfg_data,
  // input beats: tick or command
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [7:0]                  data_byte,
  input  logic                        line_level,
  // result beats
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        pull_low,
  output logic                        busy_res,
  output logic                        done_res,
  output logic [7:0]                  read_byte
);

  owm_pkg::cfg_t cfg;
  owm_pkg::res_t res;

  // Timing registers; writes are registered and always taken.
  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: each tick beat advances the phase counter one step; a command
  // beat starts a reset, write or read when idle and is dropped when busy.
  owm_core #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .data_byte  (data_byte),
    .line_level (line_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  // Unpack the result register onto the payload ports.
  assign pull_low  = res.pull_low;
  assign busy_res  = res.busy;
  assign done_res  = res.done;
  assign read_byte = res.read_byte;

  // A completing beat leaves the sequencer idle.
  `OWM_ASSERT_IMPL(a_done_not_busy, clk, rst, out_valid && done_res, !busy_res)
  // The line is only driven while a command runs.
  `OWM_ASSERT_IMPL(a_drive_when_busy, clk, rst, out_valid && pull_low, busy_res)
  // A command beat taken while idle shows busy with the line pulled low; the
  // result register holds the sequencer state of the last taken beat.
  `OWM_ASSERT_NEXT(a_start_drives, clk, rst, in_valid && in_ready && mode != 2'd0 && !busy_res, out_valid && busy_res && pull_low)

endmodule
